FILE: hw/rtl/evq_pkg.sv
// ----------------------------------------------------------------------------
// evq_pkg
// Shared types for the masked event ring queue: request codes, the stored
// event record and the status the match unit hands to the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package evq_pkg;

    // Request codes
    typedef enum logic [1:0] {
        OP_POST  = 2'd0,
        OP_GET   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_FLUSH = 2'd3
    } evq_op_t;

    // One stored event, packed into a single RAM word
    typedef struct packed {
        logic [15:0]        ev_type;
        logic [15:0]        message;
        logic [15:0]        modifiers;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [31:0]        stamp;
    } evq_rec_t;

    localparam int REC_W = $bits(evq_rec_t);

    // Match unit status toward the sequencer
    typedef struct packed {
        logic hit;     // stored type shares a bit with the mask
        logic at_end;  // stepped index reached the tail
    } evq_stat_t;

endpackage

FILE: hw/rtl/evq_ram.sv
// ----------------------------------------------------------------------------
// evq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module evq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/evq_match.sv
// ----------------------------------------------------------------------------
// evq_match
// Shared scan unit: masks the stored type, then steps either the scan
// pointer (on a miss or a peek) or the head (on a taking hit) around the ring
// and flags when the stepped index lands on the tail.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module evq_match #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic [15:0]                    slot_type,
    input  logic [15:0]                    mask,
    input  logic                           take,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] ptr,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] head,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] tail,
    output logic [$clog2(QUEUE_DEPTH)-1:0] nxt,
    output evq_pkg::evq_stat_t             stat
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    logic             hit;
    logic [IDX_W-1:0] base;

    // Type compare
    assign hit = |(slot_type & mask);

    // Index step with wrap; a taking hit advances the head instead
    assign base = (hit && take) ? head : ptr;
    assign nxt  = (base == LAST_IDX) ? '0 : base + IDX_W'(1);

    assign stat.hit    = hit;
    assign stat.at_end = (nxt == tail);

endmodule

FILE: hw/rtl/masked_event_ring_queue.sv
// ----------------------------------------------------------------------------
// masked_event_ring_queue
// Ring queue of event records with masked get, peek and flush.
// ----------------------------------------------------------------------------
// A post is taken and gives no result. Get, peek and flush scan the ring from
// head to tail through one RAM read port and one shared match unit, each slot
// examined passing through a read state and then a check state; a flush
// restarts that scan from the head after every hit. A finished result sits in
// an output register, and a new request is taken while it waits. The queue
// holds at most QUEUE_DEPTH-1 events; posting into a full queue drops the
// oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module masked_event_ring_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic [15:0]        mask,
    input  logic [15:0]        ev_type,
    input  logic [15:0]        ev_message,
    input  logic [15:0]        ev_modifiers,
    input  logic signed [15:0] ev_x,
    input  logic signed [15:0] ev_y,
    input  logic [31:0]        now_tick,
    input  logic signed [15:0] cur_x,
    input  logic signed [15:0] cur_y,
    input  logic [15:0]        cur_modifiers,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic               found,
    output logic [15:0]        out_type,
    output logic [15:0]        out_message,
    output logic [15:0]        out_modifiers,
    output logic signed [15:0] out_x,
    output logic signed [15:0] out_y,
    output logic [31:0]        out_when
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_CHK,
        ST_HOLD
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    evq_pkg::evq_op_t    op_reg, op_next;
    logic [15:0]         mask_reg, mask_next;
    logic signed [15:0]  cx_reg, cx_next;
    logic signed [15:0]  cy_reg, cy_next;
    logic [15:0]         cmod_reg, cmod_next;
    logic                res_found_reg, res_found_next;
    evq_pkg::evq_rec_t   res_rec_reg, res_rec_next;
    logic                out_vld_reg, out_vld_next;
    logic                out_found_reg, out_found_next;
    evq_pkg::evq_rec_t   out_rec_reg, out_rec_next;

    logic                in_acc;
    logic                out_free;
    evq_pkg::evq_op_t    in_op;
    evq_pkg::evq_rec_t   post_rec;
    evq_pkg::evq_rec_t   null_in_rec;
    evq_pkg::evq_rec_t   null_reg_rec;
    evq_pkg::evq_rec_t   rd_rec;
    evq_pkg::evq_rec_t   wr_rec;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [IDX_W-1:0]    nxt_idx;
    evq_pkg::evq_stat_t  mstat;
    logic [IDX_W-1:0]    tail_step;
    logic [IDX_W-1:0]    tail_step2;

    // Ring index step
    function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] idx);
        step_idx = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
    endfunction

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign in_op    = evq_pkg::evq_op_t'(op);
    assign out_free = !out_vld_reg || !out_stall;

    // Record built from a post request
    always_comb
    begin
        post_rec.ev_type   = ev_type;
        post_rec.message   = ev_message;
        post_rec.modifiers = ev_modifiers;
        post_rec.x         = ev_x;
        post_rec.y         = ev_y;
        post_rec.stamp     = now_tick;
    end

    // Null events: from live inputs (empty queue) or latched inputs (miss)
    always_comb
    begin
        null_in_rec           = '0;
        null_in_rec.modifiers = cur_modifiers;
        null_in_rec.x         = cur_x;
        null_in_rec.y         = cur_y;
        null_reg_rec           = '0;
        null_reg_rec.modifiers = cmod_reg;
        null_reg_rec.x         = cx_reg;
        null_reg_rec.y         = cy_reg;
    end

    // Record store
    evq_ram #(
        .WIDTH (evq_pkg::REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_rec),
        .raddr (ptr_reg),
        .rdata (rd_rec)
    );

    // Shared match and step unit
    evq_match #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_match (
        .slot_type (rd_rec.ev_type),
        .mask      (mask_reg),
        .take      (op_reg != evq_pkg::OP_PEEK),
        .ptr       (ptr_reg),
        .head      (head_reg),
        .tail      (tail_reg),
        .nxt       (nxt_idx),
        .stat      (mstat)
    );

    assign tail_step  = step_idx(tail_reg);
    assign tail_step2 = step_idx(tail_step);

    // RAM write: post at tail, or clear type of a taken hit
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = tail_reg;
        wr_rec    = post_rec;
        if (in_acc && (in_op == evq_pkg::OP_POST))
        begin
            ram_we = 1'b1;
        end
        else if ((state_reg == ST_CHK) && mstat.hit && (op_reg != evq_pkg::OP_PEEK))
        begin
            ram_we         = 1'b1;
            ram_waddr      = ptr_reg;
            wr_rec         = rd_rec;
            wr_rec.ev_type = '0;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        ptr_next       = ptr_reg;
        op_next        = op_reg;
        mask_next      = mask_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cmod_next      = cmod_reg;
        res_found_next = res_found_reg;
        res_rec_next   = res_rec_reg;
        out_vld_next   = out_vld_reg && out_stall;
        out_found_next = out_found_reg;
        out_rec_next   = out_rec_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    op_next   = in_op;
                    mask_next = mask;
                    cx_next   = cur_x;
                    cy_next   = cur_y;
                    cmod_next = cur_modifiers;
                    if (in_op == evq_pkg::OP_POST)
                    begin
                        tail_next = tail_step;
                        if (tail_step == head_reg)
                        begin
                            head_next = tail_step2;
                        end
                    end
                    else if (head_reg == tail_reg)
                    begin
                        res_found_next = 1'b0;
                        res_rec_next   = null_in_rec;
                        state_next     = ST_HOLD;
                    end
                    else
                    begin
                        ptr_next   = head_reg;
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (mstat.hit && (op_reg != evq_pkg::OP_FLUSH))
                begin
                    if (op_reg == evq_pkg::OP_GET)
                    begin
                        head_next = nxt_idx;
                    end
                    res_found_next = 1'b1;
                    res_rec_next   = rd_rec;
                    state_next     = ST_HOLD;
                end
                else
                begin
                    if (mstat.hit)
                    begin
                        head_next = nxt_idx;
                    end
                    ptr_next = nxt_idx;
                    if (mstat.at_end)
                    begin
                        res_found_next = 1'b0;
                        res_rec_next   = null_reg_rec;
                        state_next     = ST_HOLD;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_vld_next   = 1'b1;
                    out_found_next = res_found_reg;
                    out_rec_next   = res_rec_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        op_reg        <= op_next;
        mask_reg      <= mask_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        cmod_reg      <= cmod_next;
        res_found_reg <= res_found_next;
        res_rec_reg   <= res_rec_next;
        out_found_reg <= out_found_next;
        out_rec_reg   <= out_rec_next;
    end

    assign out_valid     = out_vld_reg;
    assign found         = out_found_reg;
    assign out_type      = out_rec_reg.ev_type;
    assign out_message   = out_rec_reg.message;
    assign out_modifiers = out_rec_reg.modifiers;
    assign out_x         = out_rec_reg.x;
    assign out_y         = out_rec_reg.y;
    assign out_when      = out_rec_reg.stamp;

    // A post always leaves the queue non-empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_op == evq_pkg::OP_POST)) |=> (head_reg != tail_reg))
        else $error("queue empty after post");

    // RAM is written only by a post request or a taking hit
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == ST_IDLE) && in_acc) || (state_reg == ST_CHK))
        else $error("unexpected RAM write");

    // A flush always ends on a miss
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_HOLD) && res_found_reg) |-> (op_reg != evq_pkg::OP_FLUSH))
        else $error("flush produced a hit result");

    // Tail only moves on a post request
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> $stable(tail_reg))
        else $error("tail moved during a scan");

    // Scan pointer never sits on the tail while reading
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |-> (ptr_reg != tail_reg))
        else $error("scan read past tail");

endmodule

FILE: bench/evq_reply_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evq_reply_checker
// Watches both channels of the masked event ring queue. It keeps its own copy
// of the event ring, works out the reply owed for every accepted query and
// compares each accepted result against the oldest owed reply, field by field.
// ----------------------------------------------------------------------------

module evq_reply_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         op,
    input  logic [15:0]        mask,
    input  logic [15:0]        ev_type,
    input  logic [15:0]        ev_message,
    input  logic [15:0]        ev_modifiers,
    input  logic signed [15:0] ev_x,
    input  logic signed [15:0] ev_y,
    input  logic [31:0]        now_tick,
    input  logic signed [15:0] cur_x,
    input  logic signed [15:0] cur_y,
    input  logic [15:0]        cur_modifiers,
    // result channel
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               found,
    input  logic [15:0]        out_type,
    input  logic [15:0]        out_message,
    input  logic [15:0]        out_modifiers,
    input  logic signed [15:0] out_x,
    input  logic signed [15:0] out_y,
    input  logic [31:0]        out_when,
    // to the bench top
    output int                 fail_count,
    output int                 replies_due
);

    // One reply as the result channel carries it
    typedef struct packed {
        logic               found;
        logic [15:0]        ev_type;
        logic [15:0]        message;
        logic [15:0]        modifiers;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [31:0]        stamp;
    } reply_t;

    // Shadow of the ring and its indices
    evq_pkg::evq_rec_t ring [QUEUE_DEPTH];
    int                head_slot = 0;
    int                tail_slot = 0;

    // Replies owed, oldest first
    reply_t   replies_owed [$];

    function automatic int next_slot_of(int i);
        return (i + 1 == QUEUE_DEPTH) ? 0 : i + 1;
    endfunction

    // First slot from head toward tail whose type shares a bit with m
    function automatic bit find_match(logic [15:0] m, output int where);
        int i;
        int n;
        i = head_slot;
        where = 0;
        for (n = 0; n < QUEUE_DEPTH && i != tail_slot; n++)
        begin
            if ((ring[i].ev_type & m) != 16'd0)
            begin
                where = i;
                return 1'b1;
            end
            i = next_slot_of(i);
        end
        return 1'b0;
    endfunction

    function automatic reply_t hit_reply(int i);
        reply_t r;
        r.found     = 1'b1;
        r.ev_type   = ring[i].ev_type;
        r.message   = ring[i].message;
        r.modifiers = ring[i].modifiers;
        r.x         = ring[i].x;
        r.y         = ring[i].y;
        r.stamp     = ring[i].stamp;
        return r;
    endfunction

    // Miss: carries the current mouse position and modifiers
    function automatic reply_t null_reply();
        reply_t r;
        r.found     = 1'b0;
        r.ev_type   = 16'd0;
        r.message   = 16'd0;
        r.modifiers = cur_modifiers;
        r.x         = cur_x;
        r.y         = cur_y;
        r.stamp     = 32'd0;
        return r;
    endfunction

    // One get: the hit slot loses its type, head steps one slot regardless
    function automatic bit take_match(logic [15:0] m, output reply_t r);
        int w;
        if (find_match(m, w))
        begin
            r = hit_reply(w);
            ring[w].ev_type = 16'd0;
            head_slot = next_slot_of(head_slot);
            return 1'b1;
        end
        r = null_reply();
        return 1'b0;
    endfunction

    // Apply one accepted request to the shadow ring, queue its reply
    function automatic void predict_request();
        reply_t            r;
        evq_pkg::evq_rec_t rec;
        int                w;
        int                n;
        case (evq_pkg::evq_op_t'(op))
            evq_pkg::OP_POST:
            begin
                rec.ev_type   = ev_type;
                rec.message   = ev_message;
                rec.modifiers = ev_modifiers;
                rec.x         = ev_x;
                rec.y         = ev_y;
                rec.stamp     = now_tick;
                ring[tail_slot] = rec;
                tail_slot = next_slot_of(tail_slot);
                // full: the oldest entry goes
                if (tail_slot == head_slot)
                    head_slot = next_slot_of(tail_slot);
            end
            evq_pkg::OP_GET:
            begin
                void'(take_match(mask, r));
                replies_owed.push_back(r);
            end
            evq_pkg::OP_PEEK:
            begin
                if (find_match(mask, w))
                    r = hit_reply(w);
                else
                    r = null_reply();
                replies_owed.push_back(r);
            end
            default:
            begin
                // flush: gets until a miss, at most one per slot
                for (n = 0; n < QUEUE_DEPTH; n++)
                begin
                    if (!take_match(mask, r))
                        break;
                end
                replies_owed.push_back(null_reply());
            end
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task automatic compare_reply(reply_t want);
        check_field("found", 32'(found), 32'(want.found));
        check_field("out_type", 32'(out_type), 32'(want.ev_type));
        check_field("out_message", 32'(out_message), 32'(want.message));
        check_field("out_modifiers", 32'(out_modifiers), 32'(want.modifiers));
        check_field("out_x", 32'(out_x), 32'(want.x));
        check_field("out_y", 32'(out_y), 32'(want.y));
        check_field("out_when", out_when, want.stamp);
    endtask

    // Results are checked before the request of the same edge is predicted
    always @(posedge clk)
    begin : watch_channels
        reply_t want;
        if (!rst_n)
        begin
            fail_count  = 0;
            replies_due = 0;
            head_slot   = 0;
            tail_slot   = 0;
            replies_owed.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (replies_owed.size() == 0)
                    report_mismatch("result with no request outstanding");
                else
                begin
                    want = replies_owed.pop_front();
                    compare_reply(want);
                end
            end
            if (in_valid && !in_stall)
                predict_request();
            replies_due = replies_owed.size();
        end
    end

endmodule

FILE: bench/masked_event_ring_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_event_ring_queue_tb
// Drives the event ring queue with a directed opening (empty queue, field
// extremes, hit behind the head, flush) and then random request streams under
// several idling mixes and one long result hold-off; the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------

module masked_event_ring_queue_tb;

    localparam int DEPTH         = 16;
    localparam int IDLE_LIMIT    = 5000;  // cycles with no handshake at all
    localparam int HOLD_CYCLES   = 400;   // long result hold-off
    localparam int DRAIN_CYCLES  = 600;   // a full flush scan and then some
    localparam int PHASE_ITEMS   = 240;
    localparam int BURST_POSTS   = 18;

    // One request on the input channel
    typedef struct {
        evq_pkg::evq_op_t   op;
        logic [15:0]        mask;
        logic [15:0]        ev_type;
        logic [15:0]        ev_message;
        logic [15:0]        ev_modifiers;
        logic signed [15:0] ev_x;
        logic signed [15:0] ev_y;
        logic [31:0]        now_tick;
        logic signed [15:0] cur_x;
        logic signed [15:0] cur_y;
        logic [15:0]        cur_modifiers;
    } request_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         op;
    logic [15:0]        mask;
    logic [15:0]        ev_type;
    logic [15:0]        ev_message;
    logic [15:0]        ev_modifiers;
    logic signed [15:0] ev_x;
    logic signed [15:0] ev_y;
    logic [31:0]        now_tick;
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;
    logic [15:0]        cur_modifiers;
    logic               out_valid;
    logic               out_stall;
    logic               found;
    logic [15:0]        out_type;
    logic [15:0]        out_message;
    logic [15:0]        out_modifiers;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [31:0]        out_when;

    int fail_count;
    int replies_due;

    // Idling mix, in percent per cycle
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int quiet_cycles = 0;

    masked_event_ring_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .mask          (mask),
        .ev_type       (ev_type),
        .ev_message    (ev_message),
        .ev_modifiers  (ev_modifiers),
        .ev_x          (ev_x),
        .ev_y          (ev_y),
        .now_tick      (now_tick),
        .cur_x         (cur_x),
        .cur_y         (cur_y),
        .cur_modifiers (cur_modifiers),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .out_type      (out_type),
        .out_message   (out_message),
        .out_modifiers (out_modifiers),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_when      (out_when)
    );

    evq_reply_checker #(
        .QUEUE_DEPTH(DEPTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .mask          (mask),
        .ev_type       (ev_type),
        .ev_message    (ev_message),
        .ev_modifiers  (ev_modifiers),
        .ev_x          (ev_x),
        .ev_y          (ev_y),
        .now_tick      (now_tick),
        .cur_x         (cur_x),
        .cur_y         (cur_y),
        .cur_modifiers (cur_modifiers),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .out_type      (out_type),
        .out_message   (out_message),
        .out_modifiers (out_modifiers),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_when      (out_when),
        .fail_count    (fail_count),
        .replies_due   (replies_due)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: random stalls, or one long hold-off on request
    initial
    begin : receiver
        int holds_done;
        holds_done = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done++;
                repeat (HOLD_CYCLES)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog: too long without any handshake ends the run
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge that accepts the request
    task automatic send_request(request_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= r.op;
        mask          <= r.mask;
        ev_type       <= r.ev_type;
        ev_message    <= r.ev_message;
        ev_modifiers  <= r.ev_modifiers;
        ev_x          <= r.ev_x;
        ev_y          <= r.ev_y;
        now_tick      <= r.now_tick;
        cur_x         <= r.cur_x;
        cur_y         <= r.cur_y;
        cur_modifiers <= r.cur_modifiers;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Bit pattern for types and masks: mostly sparse so hits and misses mix
    function automatic logic [15:0] pick_bits();
        int k;
        k = $urandom_range(99);
        if (k < 50)
            return 16'd1 << $urandom_range(15);
        else if (k < 80)
            return 16'($urandom);
        else if (k < 88)
            return 16'h0000;
        else
            return 16'hFFFF;
    endfunction

    function automatic request_t make_random_request(evq_pkg::evq_op_t code);
        request_t r;
        r.op            = code;
        r.mask          = pick_bits();
        r.ev_type       = pick_bits();
        r.ev_message    = 16'($urandom);
        r.ev_modifiers  = 16'($urandom);
        r.ev_x          = 16'($urandom);
        r.ev_y          = 16'($urandom);
        r.now_tick      = $urandom;
        r.cur_x         = 16'($urandom);
        r.cur_y         = 16'($urandom);
        r.cur_modifiers = 16'($urandom);
        return r;
    endfunction

    function automatic request_t make_post(logic [15:0] t, logic [15:0] msg,
                                           logic [15:0] md, logic [15:0] x,
                                           logic [15:0] y, logic [31:0] tick);
        request_t r;
        r = make_random_request(evq_pkg::OP_POST);
        r.ev_type      = t;
        r.ev_message   = msg;
        r.ev_modifiers = md;
        r.ev_x         = x;
        r.ev_y         = y;
        r.now_tick     = tick;
        return r;
    endfunction

    function automatic request_t make_query(evq_pkg::evq_op_t code, logic [15:0] m,
                                            logic [15:0] cx, logic [15:0] cy,
                                            logic [15:0] cm);
        request_t r;
        r = make_random_request(code);
        r.mask          = m;
        r.cur_x         = cx;
        r.cur_y         = cy;
        r.cur_modifiers = cm;
        return r;
    endfunction

    function automatic evq_pkg::evq_op_t pick_op();
        int k;
        k = $urandom_range(99);
        if (k < 45)
            return evq_pkg::OP_POST;
        else if (k < 70)
            return evq_pkg::OP_GET;
        else if (k < 88)
            return evq_pkg::OP_PEEK;
        else
            return evq_pkg::OP_FLUSH;
    endfunction

    // Random stream; now and then a burst of posts that wraps the ring
    task automatic run_phase(int n_items, int idle, int stall);
        int sent;
        int b;
        idle_pct  = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 8)
            begin
                for (b = 0; b < BURST_POSTS; b++)
                    send_request(make_random_request(evq_pkg::OP_POST));
                sent += BURST_POSTS;
            end
            else
            begin
                send_request(make_random_request(pick_op()));
                sent++;
            end
        end
    endtask

    // Stimulus and verdict
    initial
    begin : stimulus
        int n;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        op            <= evq_pkg::OP_POST;
        mask          <= 16'd0;
        ev_type       <= 16'd0;
        ev_message    <= 16'd0;
        ev_modifiers  <= 16'd0;
        ev_x          <= 16'sd0;
        ev_y          <= 16'sd0;
        now_tick      <= 32'd0;
        cur_x         <= 16'sd0;
        cur_y         <= 16'sd0;
        cur_modifiers <= 16'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: queries on an empty queue
        send_request(make_query(evq_pkg::OP_GET, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF));
        send_request(make_query(evq_pkg::OP_PEEK, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000));
        send_request(make_query(evq_pkg::OP_FLUSH, 16'h0000, 16'h0000, 16'hFFFF, 16'h5A5A));
        // field extremes
        send_request(make_post(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                               32'h0000_0000));
        send_request(make_post(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000,
                               32'hFFFF_FFFF));
        send_request(make_post(16'h8000, 16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF,
                               32'h8000_0000));
        send_request(make_post(16'h0002, 16'h1234, 16'h00FF, 16'hFFFF, 16'h0001,
                               32'h0000_0001));
        // mask of zero never matches
        send_request(make_query(evq_pkg::OP_PEEK, 16'h0000, 16'h8000, 16'h8000, 16'hFFFF));
        send_request(make_query(evq_pkg::OP_PEEK, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000));
        // hit behind the head: head entry is dropped, hit slot loses its type
        send_request(make_query(evq_pkg::OP_GET, 16'h0002, 16'h0000, 16'h0000, 16'h0000));
        send_request(make_query(evq_pkg::OP_GET, 16'h0004, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_request(make_query(evq_pkg::OP_PEEK, 16'hFFFF, 16'h0001, 16'h0002, 16'h0003));
        // a type of zero never matches either
        send_request(make_post(16'h0000, 16'hAAAA, 16'h5555, 16'h0100, 16'hFF00,
                               32'h1234_5678));
        send_request(make_post(16'h0004, 16'h5555, 16'hAAAA, 16'hFF00, 16'h0100,
                               32'h8765_4321));
        send_request(make_query(evq_pkg::OP_GET, 16'h0004, 16'h0000, 16'h0000, 16'h0000));
        // flush then confirm nothing matches
        send_request(make_post(16'h0010, 16'h0F0F, 16'hF0F0, 16'h0000, 16'h0000,
                               32'hDEAD_BEEF));
        send_request(make_post(16'h0030, 16'hF0F0, 16'h0F0F, 16'h7FFF, 16'h7FFF,
                               32'hCAFE_F00D));
        send_request(make_query(evq_pkg::OP_FLUSH, 16'hFFFF, 16'h8000, 16'h8000, 16'hFFFF));
        send_request(make_query(evq_pkg::OP_PEEK, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000));
        send_request(make_query(evq_pkg::OP_GET, 16'h0001, 16'h1111, 16'h2222, 16'h3333));

        // Random phases under different idling mixes
        run_phase(PHASE_ITEMS, 0, 0);
        run_phase(PHASE_ITEMS, 46, 0);
        run_phase(PHASE_ITEMS, 0, 46);
        run_phase(PHASE_ITEMS, 25, 25);

        // Long result hold-off while requests keep coming: input must back up
        idle_pct  = 0;
        stall_pct = 0;
        hold_requests++;
        for (n = 0; n < 8; n++)
            send_request(make_random_request(evq_pkg::OP_POST));
        for (n = 0; n < 32; n++)
            send_request(make_random_request(($urandom_range(1) != 0) ?
                                             evq_pkg::OP_GET : evq_pkg::OP_PEEK));
        run_phase(60, 10, 10);

        // Drain
        in_valid <= 1'b0;
        @(posedge clk);
        while (replies_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
